// ===== rtl/core/debug_packet_deframer_top_macros.svh =====
// Assertion macros shared by the debug packet deframer modules.
`ifndef DEBUG_PACKET_DEFRAMER_TOP_MACROS_SVH
`define DEBUG_PACKET_DEFRAMER_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define DPD_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("deframer assertion failed");

// Next-cycle implication.
`define DPD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("deframer assertion failed");

`else

`define DPD_ASSERT_IMP(label, clk, rst, ante, cons)
`define DPD_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/core/dpd_pkg.sv =====
// Types, constants and helpers for the debug packet deframer.
package dpd_pkg;

   localparam int DPD_MAX_PAYLOAD = 1024;
   localparam int LEN_W           = 11;

   localparam logic [7:0] SOF_BYTE = 8'h24;  // '$'
   localparam logic [7:0] EOF_BYTE = 8'h23;  // '#'
   localparam logic [7:0] ESC_BYTE = 8'h7d;
   localparam logic [7:0] ESC_XOR  = 8'h20;

   typedef enum logic [2:0] {
      PH_HUNT,
      PH_DATA,
      PH_ESC,
      PH_CKHI,
      PH_CKLO
   } phase_type;

   typedef enum logic [2:0] {
      EV_PAYLOAD  = 3'd0,
      EV_ACCEPT   = 3'd1,
      EV_BADSUM   = 3'd2,
      EV_OVERFLOW = 3'd3,
      EV_RESTART  = 3'd4
   } event_kind_type;

   typedef struct packed {
      logic              produce;
      event_kind_type    kind;
      logic [7:0]        data_byte;
      logic [LEN_W-1:0]  payload_length;
      logic [7:0]        computed_sum;
   } result_type;

   // Bits 3..0 hold the digit value, bit 4 flags a non-hex byte.
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [4:0] v;
      v = 5'h10;
      if (c >= 8'h61 && c <= 8'h66) begin
         v = 5'(c - 8'h57);
      end else if (c >= 8'h30 && c <= 8'h39) begin
         v = 5'(c - 8'h30);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         v = 5'(c - 8'h37);
      end
      return v;
   endfunction

endpackage

// ===== rtl/core/debug_packet_deframer_top.sv =====
// Each byte is held in the input register, then its result beat is loaded into the result register.
// Throughput: one byte per cycle; input stalls only while a beat-making byte waits on a stalled result.
// Bytes that end no event ('#' or escape below the payload limit, checksum high digit, hunting) give no beat.
// Synchronous active-high reset: hunt for '$', sum and count cleared, no beats held.
`include "debug_packet_deframer_top_macros.svh"

module debug_packet_deframer_top
   import dpd_pkg::*;
#(
   parameter int MAX_PAYLOAD = DPD_MAX_PAYLOAD
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [7:0]       req_rx_byte,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [2:0]       rsp_event_kind,
   output logic [7:0]       rsp_data_byte,
   output logic [LEN_W-1:0] rsp_payload_length,
   output logic [7:0]       rsp_computed_sum
);

   logic       in_vld_ff, in_vld_in;
   logic [7:0] in_byte_ff;
   logic       out_vld_ff, out_vld_in;
   result_type out_ff;
   result_type res;
   logic       advance;

   dpd_frame_fsm #(
      .MAX_PAYLOAD(MAX_PAYLOAD)
   ) u_fsm (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .rx_byte(in_byte_ff),
      .res    (res)
   );

   // advance when the byte makes no beat or the result register has room
   assign advance   = in_vld_ff && (!res.produce || !out_vld_ff || !rsp_stall);
   assign req_stall = in_vld_ff && !advance;

   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_valid && !req_stall) begin
         in_vld_in = 1'b1;
      end else if (advance) begin
         in_vld_in = 1'b0;
      end
      out_vld_in = out_vld_ff;
      if (advance && res.produce) begin
         out_vld_in = 1'b1;
      end else if (out_vld_ff && !rsp_stall) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_rx_byte;
      end
      if (advance && res.produce) begin
         out_ff <= res;
      end
   end

   assign rsp_valid          = out_vld_ff;
   assign rsp_event_kind     = out_ff.kind;
   assign rsp_data_byte      = out_ff.data_byte;
   assign rsp_payload_length = out_ff.payload_length;
   assign rsp_computed_sum   = out_ff.computed_sum;

   `DPD_ASSERT_NEXT(a_result_loaded, clock, reset, advance && res.produce, out_vld_ff)
   `DPD_ASSERT_IMP(a_no_overwrite, clock, reset, out_vld_ff && rsp_stall, !(advance && res.produce))
   `DPD_ASSERT_IMP(a_stall_only_when_busy, clock, reset, req_stall, in_vld_ff)

endmodule

// ===== rtl/core/dpd_frame_fsm.sv =====
// Framing state machine: phase, running sum, count and checksum digit.
`include "debug_packet_deframer_top_macros.svh"

module dpd_frame_fsm
   import dpd_pkg::*;
#(
   parameter int MAX_PAYLOAD = DPD_MAX_PAYLOAD
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] rx_byte,
   output result_type res
);

   localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);

   phase_type         phase_ff, phase_in;
   logic [7:0]        sum_ff, sum_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [4:0]        high_ff, high_in;

   logic [4:0]        lo_digit;
   logic [7:0]        got_sum;
   logic              full;

   assign lo_digit = hex_value(rx_byte);
   assign got_sum  = {high_ff[3:0], lo_digit[3:0]};
   assign full     = (cnt_ff == CNT_W'(MAX_PAYLOAD));

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         sum_ff   <= '0;
         cnt_ff   <= '0;
         high_ff  <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         sum_ff   <= sum_in;
         cnt_ff   <= cnt_in;
         high_ff  <= high_in;
      end
   end

   always_comb begin
      phase_in      = phase_ff;
      sum_in        = sum_ff;
      cnt_in        = cnt_ff;
      high_in       = high_ff;
      res.produce   = 1'b0;
      res.kind      = EV_PAYLOAD;
      res.data_byte = rx_byte;
      unique case (phase_ff)
         PH_DATA, PH_ESC: begin
            if (full) begin
               // drop the byte and hunt again
               res.produce = 1'b1;
               res.kind    = EV_OVERFLOW;
               phase_in    = PH_HUNT;
            end else if (phase_ff == PH_ESC) begin
               sum_in        = sum_ff + rx_byte;
               cnt_in        = cnt_ff + 1'b1;
               phase_in      = PH_DATA;
               res.produce   = 1'b1;
               res.data_byte = rx_byte ^ ESC_XOR;
            end else if (rx_byte == SOF_BYTE) begin
               sum_in      = '0;
               cnt_in      = '0;
               res.produce = 1'b1;
               res.kind    = EV_RESTART;
            end else if (rx_byte == EOF_BYTE) begin
               phase_in = PH_CKHI;
            end else begin
               // escape byte still counts toward the sum
               sum_in = sum_ff + rx_byte;
               if (rx_byte == ESC_BYTE) begin
                  phase_in = PH_ESC;
               end else begin
                  cnt_in      = cnt_ff + 1'b1;
                  res.produce = 1'b1;
               end
            end
         end
         PH_CKHI: begin
            high_in  = hex_value(rx_byte);
            phase_in = PH_CKLO;
         end
         PH_CKLO: begin
            res.produce   = 1'b1;
            res.data_byte = got_sum;
            if (!high_ff[4] && !lo_digit[4] && got_sum == sum_ff) begin
               res.kind = EV_ACCEPT;
            end else begin
               res.kind = EV_BADSUM;
            end
            phase_in = PH_HUNT;
         end
         default: begin
            if (rx_byte == SOF_BYTE) begin
               sum_in   = '0;
               cnt_in   = '0;
               phase_in = PH_DATA;
            end
         end
      endcase
      res.payload_length = LEN_W'(cnt_in);
      res.computed_sum   = sum_in;
   end

   `DPD_ASSERT_IMP(a_accept_from_cklo, clock, reset, step && res.produce && res.kind == EV_ACCEPT, phase_ff == PH_CKLO)
   `DPD_ASSERT_NEXT(a_overflow_hunts, clock, reset, step && res.produce && res.kind == EV_OVERFLOW, phase_ff == PH_HUNT)
   `DPD_ASSERT_NEXT(a_restart_clears, clock, reset, step && res.produce && res.kind == EV_RESTART, cnt_ff == '0 && sum_ff == 8'h00)
   `DPD_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, cnt_ff <= CNT_W'(MAX_PAYLOAD))

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the debug packet deframer, with random framed traffic and stalls.
`timescale 1ns / 100ps

module tb
   import dpd_pkg::*;
();

   localparam int DRAIN_MARK   = -1;
   localparam int RANDOM_ITEMS = 500;

   typedef logic [7:0] byte_seq_type[$];

   typedef enum int {
      FR_GOOD,
      FR_BADSUM,
      FR_BAD_HI,
      FR_BAD_LO,
      FR_OPEN
   } frame_flavor_type;

   typedef struct {
      event_kind_type   kind;
      logic [7:0]       data_byte;
      logic [LEN_W-1:0] plen;
      logic [7:0]       sum;
   } frame_event_type;

   logic             clock;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   logic [7:0]       req_rx_byte = 8'h00;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   logic [2:0]       rsp_event_kind;
   logic [7:0]       rsp_data_byte;
   logic [LEN_W-1:0] rsp_payload_length;
   logic [7:0]       rsp_computed_sum;

   int              pending_q[$];
   frame_event_type expected_events[$];

   // shadow of the deframer state
   phase_type  frame_phase;
   logic [7:0] frame_sum;
   int         frame_len;
   logic [4:0] ck_high;

   int bytes_queued = 0;
   int bytes_accepted = 0;
   int error_count = 0;
   int send_gap = 0;
   int stall_left = 0;
   int calm_left = 0;
   bit calm = 1'b1;
   bit req_taken = 1'b0;
   bit rx_hold = 1'b0;

   debug_packet_deframer_top u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_event_kind     (rsp_event_kind),
      .rsp_data_byte      (rsp_data_byte),
      .rsp_payload_length (rsp_payload_length),
      .rsp_computed_sum   (rsp_computed_sum)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Bit 4 flags a byte that is not a hex digit.
   function automatic logic [4:0] digit_of(input logic [7:0] c);
      logic [4:0] d;
      d = 5'h10;
      if (c >= "0" && c <= "9") begin
         d = {1'b0, c[3:0]};
      end else if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) begin
         d = {1'b0, c[3:0] + 4'd9};
      end
      return d;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
      if (n < 4'd10) begin
         return 8'h30 | {4'h0, n};
      end
      return (upper ? 8'h40 : 8'h60) | {4'h0, n - 4'd9};
   endfunction

   function automatic logic [7:0] non_hex();
      logic [7:0] c;
      logic [4:0] d;
      do begin
         c = 8'($urandom);
         d = digit_of(c);
      end while (!d[4]);
      return c;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // n decoded payload bytes; escape pairs may carry any byte
   function automatic byte_seq_type random_body(input int n);
      byte_seq_type body;
      logic [7:0]   c;
      int           k;
      for (k = 0; k < n; k++) begin
         if ($urandom_range(0, 99) < 15) begin
            body.push_back(ESC_BYTE);
            body.push_back(8'($urandom));
         end else begin
            do c = 8'($urandom);
            while (c == SOF_BYTE || c == EOF_BYTE || c == ESC_BYTE);
            body.push_back(c);
         end
      end
      return body;
   endfunction

   function void push_event(input event_kind_type kind, input logic [7:0] data);
      frame_event_type ev;
      ev.kind      = kind;
      ev.data_byte = data;
      ev.plen      = LEN_W'(frame_len);
      ev.sum       = frame_sum;
      expected_events.push_back(ev);
   endfunction

   function void frame_step(input logic [7:0] c);
      logic [4:0] lo_digit;
      logic [7:0] got;
      case (frame_phase)
         PH_DATA, PH_ESC: begin
            if (frame_len >= DPD_MAX_PAYLOAD) begin
               push_event(EV_OVERFLOW, c);
               frame_phase = PH_HUNT;
            end else if (frame_phase == PH_ESC) begin
               frame_sum   = frame_sum + c;
               frame_len   = frame_len + 1;
               frame_phase = PH_DATA;
               push_event(EV_PAYLOAD, c ^ ESC_XOR);
            end else if (c == SOF_BYTE) begin
               frame_sum = 8'h00;
               frame_len = 0;
               push_event(EV_RESTART, c);
            end else if (c == EOF_BYTE) begin
               frame_phase = PH_CKHI;
            end else begin
               // the escape byte itself counts in the sum
               frame_sum = frame_sum + c;
               if (c == ESC_BYTE) begin
                  frame_phase = PH_ESC;
               end else begin
                  frame_len = frame_len + 1;
                  push_event(EV_PAYLOAD, c);
               end
            end
         end
         PH_CKHI: begin
            ck_high     = digit_of(c);
            frame_phase = PH_CKLO;
         end
         PH_CKLO: begin
            lo_digit = digit_of(c);
            got      = {ck_high[3:0], lo_digit[3:0]};
            if (!ck_high[4] && !lo_digit[4] && got == frame_sum) begin
               push_event(EV_ACCEPT, got);
            end else begin
               push_event(EV_BADSUM, got);
            end
            frame_phase = PH_HUNT;
         end
         default: begin
            if (c == SOF_BYTE) begin
               frame_sum   = 8'h00;
               frame_len   = 0;
               frame_phase = PH_DATA;
            end else begin
               frame_phase = PH_HUNT;
            end
         end
      endcase
   endfunction

   task automatic push_byte(input logic [7:0] b);
      pending_q.push_back(int'(b));
      bytes_queued++;
   endtask

   task automatic queue_frame(input byte_seq_type body, input frame_flavor_type flavor);
      logic [7:0] sum;
      logic [7:0] hi;
      logic [7:0] lo;
      bit         upper;
      sum = 8'h00;
      push_byte(SOF_BYTE);
      foreach (body[i]) begin
         push_byte(body[i]);
         sum = sum + body[i];
      end
      if (flavor != FR_OPEN) begin
         push_byte(EOF_BYTE);
         upper = 1'($urandom_range(0, 1));
         if (flavor == FR_BADSUM) begin
            sum = sum ^ 8'($urandom_range(1, 255));
         end
         hi = hex_char(sum[7:4], upper);
         lo = hex_char(sum[3:0], upper);
         if (flavor == FR_BAD_HI) hi = non_hex();
         if (flavor == FR_BAD_LO) lo = non_hex();
         push_byte(hi);
         push_byte(lo);
      end
   endtask

   task automatic log_mismatch(input string msg);
      error_count++;
      if (error_count <= 10) begin
         $display("mismatch at %0t: %s", $time, msg);
      end
   endtask

   // Predict on accepted input beats, then check accepted result beats.
   always @(posedge clock) begin
      frame_event_type want;
      if (reset) begin
         frame_phase = PH_HUNT;
         frame_sum   = 8'h00;
         frame_len   = 0;
         ck_high     = 5'h00;
         req_taken   = 1'b0;
         expected_events.delete();
      end else begin
         req_taken = req_valid && !req_stall;
         if (req_taken) begin
            frame_step(req_rx_byte);
            bytes_accepted++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_events.size() == 0) begin
               log_mismatch($sformatf("unexpected beat kind %0d data %02h len %0d sum %02h",
                  rsp_event_kind, rsp_data_byte, rsp_payload_length, rsp_computed_sum));
            end else begin
               want = expected_events.pop_front();
               if (rsp_event_kind !== want.kind || rsp_data_byte !== want.data_byte ||
                   rsp_payload_length !== want.plen || rsp_computed_sum !== want.sum) begin
                  log_mismatch($sformatf(
                     "kind %0d data %02h len %0d sum %02h, want %0d %02h %0d %02h",
                     rsp_event_kind, rsp_data_byte, rsp_payload_length, rsp_computed_sum,
                     want.kind, want.data_byte, want.plen, want.sum));
               end
            end
         end
      end
   end

   // Alternate busy stretches with quiet ones where neither side idles.
   always @(posedge clock) begin
      if (calm_left == 0) begin
         calm      = !calm;
         calm_left = $urandom_range(40, 400);
      end else begin
         calm_left--;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else if (!req_valid || req_taken) begin
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (pending_q.size() != 0 && pending_q[0] == DRAIN_MARK) begin
            // hold until every result so far has come back
            req_valid <= 1'b0;
            if (expected_events.size() == 0) begin
               void'(pending_q.pop_front());
            end
         end else if (pending_q.size() != 0) begin
            req_rx_byte <= 8'(pending_q.pop_front());
            req_valid   <= 1'b1;
            send_gap = calm ? 0 : pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (stall_left > 0) begin
            stall_left--;
         end else if (!calm && $urandom_range(0, 2) == 0) begin
            stall_left = pick_gap();
         end
         rsp_stall <= rx_hold || stall_left > 0;
      end
   end

   // Long receiver hold-off while the sender keeps offering beats.
   initial begin
      while (bytes_accepted < 150) @(posedge clock);
      rx_hold = 1'b1;
      repeat (250) @(posedge clock);
      rx_hold = 1'b0;
   end

   initial begin
      byte_seq_type     body;
      int               random_items;
      int               mark;
      int               pick;
      bit               long_done;
      bit               drain_done;
      frame_flavor_type flavor;

      random_items = 0;
      long_done    = 1'b0;
      drain_done   = 1'b0;

      // hunting noise, then empty frame, escapes, bad high digit, restart, bad sum, bad low digit
      push_byte(8'h00);
      push_byte(8'hff);
      push_byte(EOF_BYTE);
      body = {};
      queue_frame(body, FR_GOOD);
      body = {"a", 8'hff, ESC_BYTE, SOF_BYTE, ESC_BYTE, ESC_BYTE};
      queue_frame(body, FR_GOOD);
      body = {8'h7f};
      queue_frame(body, FR_BAD_HI);
      body = {8'h01};
      queue_frame(body, FR_OPEN);
      body = {8'h80, ESC_BYTE, EOF_BYTE};
      queue_frame(body, FR_BADSUM);
      body = {8'h00};
      queue_frame(body, FR_BAD_LO);
      pending_q.push_back(DRAIN_MARK);

      while (random_items < RANDOM_ITEMS) begin
         mark = bytes_queued;
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            repeat ($urandom_range(1, 5)) push_byte(8'($urandom));
         end else begin
            if (pick < 60) flavor = FR_GOOD;
            else if (pick < 72) flavor = FR_BADSUM;
            else if (pick < 78) flavor = FR_BAD_HI;
            else if (pick < 84) flavor = FR_BAD_LO;
            else flavor = FR_OPEN;
            queue_frame(random_body($urandom_range(0, (pick % 5 == 0) ? 40 : 10)), flavor);
            random_items += bytes_queued - mark;
         end
         if (!long_done && random_items >= 100) begin
            // fill a frame to the limit, then overflow on '$'
            queue_frame(random_body(DPD_MAX_PAYLOAD), FR_OPEN);
            push_byte(SOF_BYTE);
            long_done = 1'b1;
         end
         if (!drain_done && random_items >= 300) begin
            pending_q.push_back(DRAIN_MARK);
            drain_done = 1'b1;
         end
      end

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (bytes_accepted < bytes_queued) @(posedge clock);
      while (expected_events.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (error_count == 0 && expected_events.size() == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

   initial begin
      #25_000_000;
      $display("tb: errors");
      $finish;
   end

endmodule
